>>> rtl/ism_pkg.sv
// ism_pkg: shared codes, widths and cell control type for the interval set block.
// No dependencies; imported by every module of the block.
package ism_pkg;

	localparam int DEF_MAX_RANGES = 64;
	localparam int DEF_KEY_BITS   = 32;

	localparam int FUNC_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int CNT_OUT_W = 7;
	localparam int OUT_USED  = 1 + STATUS_W + CNT_OUT_W;
	localparam int OUT_TDW   = ((OUT_USED + 7) / 8) * 8;

	localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FIN   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FINAL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd3;

	typedef enum logic [1:0] {
		SRC_BCAST = 2'd0,
		SRC_LEFT  = 2'd1,
		SRC_RIGHT = 2'd2
	} src_t;

	typedef struct packed {
		logic load;
		src_t src;
	} cell_ctl_t;

endpackage

>>> rtl/ism_cell.sv
// ism_cell: one storage cell of the sorted range chain.
// Loads from its left or right neighbor or from the broadcast range; compares against it.
// Depends on ism_pkg.
module ism_cell #(
	parameter int KEY_BITS = ism_pkg::DEF_KEY_BITS
) (
	input  logic                clk,
	input  ism_pkg::cell_ctl_t  ctl,
	input  logic [KEY_BITS-1:0] left_start,
	input  logic [KEY_BITS:0]   left_stop,
	input  logic [KEY_BITS-1:0] right_start,
	input  logic [KEY_BITS:0]   right_stop,
	input  logic [KEY_BITS-1:0] bc_start,
	input  logic [KEY_BITS:0]   bc_stop,
	input  logic [KEY_BITS-1:0] key,
	output logic [KEY_BITS-1:0] start,
	output logic [KEY_BITS:0]   stop,
	output logic                bc_first,
	output logic                hit
);
	import ism_pkg::*;

	logic [KEY_BITS-1:0] start_q;
	logic [KEY_BITS:0]   stop_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			unique case (ctl.src)
				SRC_LEFT: begin
					start_q <= left_start;
					stop_q  <= left_stop;
				end
				SRC_RIGHT: begin
					start_q <= right_start;
					stop_q  <= right_stop;
				end
				default: begin
					start_q <= bc_start;
					stop_q  <= bc_stop;
				end
			endcase
		end
	end

	// broadcast range sorts ahead of this one: smaller start, or same start and larger stop
	assign bc_first = (bc_start < start_q) || ((bc_start == start_q) && (bc_stop > stop_q));
	assign hit      = (start_q <= key) && ({1'b0, key} < stop_q);
	assign start    = start_q;
	assign stop     = stop_q;

endmodule

>>> rtl/interval_set_merge_lookup.sv
// interval_set_merge_lookup: top level, sorted range chain with insert, merge pass and lookup.
// Depends on ism_pkg and ism_cell.
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser func; s_tdata start, stop, key
// m_       out  m_tvalid/m_tready  m_tdata found, status, range_count
//
// Add and query results are registered and shown in the cycle after the item is taken.
// Add inserts in sorted place: every cell compares against the new range in parallel.
// Finalize walks the chain by shifting it left once per stored range, then places
// the last merged range.
// One item at a time; a new item is taken once the result slot is free or draining.
// Reset clears the count and the finalized mark; cell contents are not cleared.
module interval_set_merge_lookup #(
	parameter int MAX_RANGES = ism_pkg::DEF_MAX_RANGES,
	parameter int KEY_BITS   = ism_pkg::DEF_KEY_BITS,
	localparam int IN_TDW    = ((3 * KEY_BITS + 1 + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [IN_TDW-1:0]          s_tdata,  // range_start, range_stop, query_key
	input  logic [ism_pkg::FUNC_W-1:0] s_tuser,  // func
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [ism_pkg::OUT_TDW-1:0] m_tdata  // found, status, range_count
);
	import ism_pkg::*;

	localparam int CW = $clog2(MAX_RANGES + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_FIN  = 2'b10
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic                finalized_q;
	logic [CW-1:0]       r_q;
	logic [CW-1:0]       w_q;
	logic [KEY_BITS-1:0] cur_start_q;
	logic [KEY_BITS:0]   cur_stop_q;
	logic                out_vld_q;
	logic [OUT_TDW-1:0]  out_q;

	logic [KEY_BITS-1:0] in_start;
	logic [KEY_BITS:0]   in_stop_raw;
	logic [KEY_BITS:0]   in_stop;
	logic [KEY_BITS-1:0] in_key;
	logic                acc;
	logic                bad_range;
	logic                full;
	logic                add_ok;

	logic [KEY_BITS-1:0] c_start [MAX_RANGES];
	logic [KEY_BITS:0]   c_stop  [MAX_RANGES];
	logic [MAX_RANGES-1:0] c_first;
	logic [MAX_RANGES-1:0] c_hit;
	logic [MAX_RANGES-1:0] c_valid;
	logic [MAX_RANGES-1:0] gt;
	cell_ctl_t           ctl [MAX_RANGES];

	logic [KEY_BITS-1:0] bc_start;
	logic [KEY_BITS:0]   bc_stop;
	logic                fin_run;
	logic                fin_done;
	logic                overlap;
	logic [KEY_BITS-1:0] mrg_start;
	logic [KEY_BITS:0]   mrg_stop;
	logic                emit;
	logic                wr_en;
	logic [CW-1:0]       wr_idx;
	logic                any_hit;
	logic [CW-1:0]       add_count;
	logic [CW-1:0]       fin_count;

	assign in_start    = s_tdata[KEY_BITS-1:0];
	assign in_stop_raw = s_tdata[2*KEY_BITS:KEY_BITS];
	assign in_key      = s_tdata[3*KEY_BITS:2*KEY_BITS+1];
	// stop above the key space saturates to 2^KEY_BITS
	assign in_stop     = (in_stop_raw[KEY_BITS] && (in_stop_raw[KEY_BITS-1:0] != '0)) ?
	                     {1'b1, {KEY_BITS{1'b0}}} : in_stop_raw;

	assign s_tready  = (state_q == S_IDLE) && (!out_vld_q || m_tready);
	assign acc       = s_tvalid && s_tready;
	assign bad_range = {1'b0, in_start} > in_stop;
	assign full      = count_q >= CW'(MAX_RANGES);
	assign add_ok    = acc && (s_tuser == FUNC_ADD) && !bad_range && !full;

	assign fin_run  = (state_q == S_FIN) && (r_q != count_q);
	assign fin_done = (state_q == S_FIN) && (r_q == count_q);

	assign overlap = ((cur_start_q <= c_start[0]) && ({1'b0, c_start[0]} < cur_stop_q)) ||
	                 ((c_start[0] <= cur_start_q) && ({1'b0, cur_start_q} < c_stop[0]));
	assign mrg_start = (cur_start_q < c_start[0]) ? cur_start_q : c_start[0];
	assign mrg_stop  = (cur_stop_q > c_stop[0]) ? cur_stop_q : c_stop[0];

	assign emit   = fin_run && (r_q != '0) && !overlap;
	assign wr_en  = emit || (fin_done && (count_q != '0));
	// emitted ranges land where the remaining shifts carry them to slot w
	assign wr_idx = fin_done ? w_q : CW'(w_q + count_q - r_q - 1'b1);

	assign bc_start = (state_q == S_FIN) ? cur_start_q : in_start;
	assign bc_stop  = (state_q == S_FIN) ? cur_stop_q  : in_stop;

	assign gt      = c_valid & c_first;
	assign any_hit = |(c_valid & c_hit);

	genvar i;
	generate
		for (i = 0; i < MAX_RANGES; i++) begin : g_cell
			localparam int LI = (i == 0) ? 0 : i - 1;
			localparam int RI = (i == MAX_RANGES - 1) ? i : i + 1;
			logic gt_left;
			logic at_tail;
			logic at_wr;

			assign c_valid[i] = CW'(i) < count_q;
			assign gt_left    = (i != 0) && gt[LI];
			assign at_tail    = CW'(i) == count_q;
			assign at_wr      = wr_en && (wr_idx == CW'(i));

			always_comb begin
				ctl[i].load = 1'b0;
				ctl[i].src  = SRC_BCAST;
				if (add_ok) begin
					ctl[i].load = gt[i] || at_tail;
					ctl[i].src  = ((gt[i] || at_tail) && gt_left) ? SRC_LEFT : SRC_BCAST;
				end else if (fin_run) begin
					ctl[i].load = 1'b1;
					ctl[i].src  = at_wr ? SRC_BCAST : SRC_RIGHT;
				end else if (fin_done) begin
					ctl[i].load = at_wr;
					ctl[i].src  = SRC_BCAST;
				end
			end

			ism_cell #(
				.KEY_BITS(KEY_BITS)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl[i]),
				.left_start (c_start[LI]),
				.left_stop  (c_stop[LI]),
				.right_start(c_start[RI]),
				.right_stop (c_stop[RI]),
				.bc_start   (bc_start),
				.bc_stop    (bc_stop),
				.key        (in_key),
				.start      (c_start[i]),
				.stop       (c_stop[i]),
				.bc_first   (c_first[i]),
				.hit        (c_hit[i])
			);
		end
	endgenerate

	assign add_count = add_ok ? CW'(count_q + 1'b1) : count_q;
	assign fin_count = (count_q == '0) ? '0 : CW'(w_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			finalized_q <= 1'b0;
			r_q         <= '0;
			w_q         <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			priority if (acc) begin
				out_vld_q <= (s_tuser != FUNC_FIN);
			end else if (fin_done) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (s_tuser == FUNC_FIN) begin
							state_q <= S_FIN;
							r_q     <= '0;
							w_q     <= '0;
						end
						if (add_ok) begin
							count_q     <= add_count;
							finalized_q <= 1'b0;
						end
					end
				end
				S_FIN: begin
					if (fin_run) begin
						r_q <= CW'(r_q + 1'b1);
						if (emit) begin
							w_q <= CW'(w_q + 1'b1);
						end
					end else begin
						count_q     <= fin_count;
						finalized_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin_run) begin
			if ((r_q == '0) || !overlap) begin
				cur_start_q <= c_start[0];
				cur_stop_q  <= c_stop[0];
			end else begin
				cur_start_q <= mrg_start;
				cur_stop_q  <= mrg_stop;
			end
		end
		if (fin_done) begin
			out_q <= {{(OUT_TDW - OUT_USED){1'b0}}, CNT_OUT_W'(fin_count), ST_OK, 1'b0};
		end else if (acc) begin
			unique case (s_tuser)
				FUNC_ADD: begin
					out_q <= {{(OUT_TDW - OUT_USED){1'b0}}, CNT_OUT_W'(add_count),
					          bad_range ? ST_BAD_RANGE : (full ? ST_FULL : ST_OK), 1'b0};
				end
				FUNC_QUERY: begin
					out_q <= {{(OUT_TDW - OUT_USED){1'b0}}, CNT_OUT_W'(count_q),
					          finalized_q ? ST_OK : ST_NOT_FINAL, finalized_q && any_hit};
				end
				default: begin
					out_q <= {{(OUT_TDW - OUT_USED){1'b0}}, CNT_OUT_W'(count_q), ST_OK, 1'b0};
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule

>>> rtl/ism_checker.sv
// ism_checker: port-level checks for interval_set_merge_lookup, bound to the top level.
// Depends on ism_pkg.
module ism_checker #(
	parameter int MAX_RANGES = ism_pkg::DEF_MAX_RANGES,
	parameter int KEY_BITS   = ism_pkg::DEF_KEY_BITS,
	localparam int IN_TDW    = ((3 * KEY_BITS + 1 + 7) / 8) * 8
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [IN_TDW-1:0]           s_tdata,
	input logic [ism_pkg::FUNC_W-1:0]  s_tuser,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [ism_pkg::OUT_TDW-1:0] m_tdata
);
	import ism_pkg::*;

	localparam logic [CNT_OUT_W-1:0] FULL_CNT = CNT_OUT_W'(MAX_RANGES);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[2:1] == ST_OK)
		else $error("found set on a result with an error status");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:1] == ST_FULL) |-> m_tdata[9:3] == FULL_CNT)
		else $error("table full reported below capacity");

endmodule

bind interval_set_merge_lookup ism_checker #(
	.MAX_RANGES(MAX_RANGES),
	.KEY_BITS  (KEY_BITS)
) u_ism_checker (.*);
